### design/mrfc_pkg.sv
package mrfc_pkg;

   // CRC-16/MODBUS constants
   localparam logic [15:0] CRC_START = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'hA001;

   // frame status codes
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_SHORT = 3'd1;
   localparam logic [2:0] ST_LONG  = 3'd2;
   localparam logic [2:0] ST_CRC   = 3'd3;
   localparam logic [2:0] ST_ADDR  = 3'd4;
   localparam logic [2:0] ST_FUNC  = 3'd5;

   // supported function codes
   localparam logic [7:0] FN_READ_HOLDING = 8'd3;
   localparam logic [7:0] FN_READ_INPUT   = 8'd4;
   localparam logic [7:0] FN_WRITE_SINGLE = 8'd6;

   localparam int MIN_FRAME_BYTES = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_frame;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  frame_status;
      logic [7:0]  function_code;
      logic [7:0]  register_low;
      logic [15:0] value_word;
      logic [15:0] computed_crc;
      logic [8:0]  frame_length;
   } rsp_word_type;

   // one byte through the reflected CRC, eight bit steps
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### design/mrfc_frame_core.sv
module mrfc_frame_core import mrfc_pkg::*; #(
   parameter int MAX_FRAME_BYTES = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_word_type in_word,
   input  logic [7:0]   station_address,
   output rsp_word_type result
);

   localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 2);
   localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_FRAME_BYTES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);
   localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_FRAME_BYTES);

   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       held0_ff, held0_in;
   logic [7:0]       held1_ff, held1_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       addr_ff, addr_in;
   logic [7:0]       func_ff, func_in;
   logic [7:0]       reg_ff, reg_in;
   logic [15:0]      value_ff, value_in;
   logic [15:0]      rx_crc;
   logic             func_ok;
   logic [2:0]       status;
   logic [7:0]       b;

   assign b = in_word.data_byte;

   // next frame state for this byte
   always_comb begin
      crc_in   = (cnt_ff >= CNT_W'(2)) ? crc_byte(crc_ff, held0_ff) : crc_ff;
      held0_in = held1_ff;
      held1_in = b;
      addr_in  = (cnt_ff == CNT_W'(0)) ? b : addr_ff;
      func_in  = (cnt_ff == CNT_W'(1)) ? b : func_ff;
      reg_in   = (cnt_ff == CNT_W'(3)) ? b : reg_ff;
      value_in = value_ff;
      if (cnt_ff == CNT_W'(4)) begin
         value_in = {b, value_ff[7:0]};
      end else if (cnt_ff == CNT_W'(5)) begin
         value_in = {value_ff[15:8], b};
      end
      cnt_in = (cnt_ff < CNT_SAT) ? cnt_ff + CNT_W'(1) : cnt_ff;
   end

   // frame check against the trailing pair, high byte first
   assign rx_crc  = {held1_ff, b};
   assign func_ok = (func_in == FN_READ_HOLDING) || (func_in == FN_READ_INPUT) ||
                    (func_in == FN_WRITE_SINGLE);

   always_comb begin
      if (cnt_in < CNT_MIN) begin
         status = ST_SHORT;
      end else if (cnt_in > CNT_MAX) begin
         status = ST_LONG;
      end else if (crc_in != rx_crc) begin
         status = ST_CRC;
      end else if (addr_in != station_address) begin
         status = ST_ADDR;
      end else if (!func_ok) begin
         status = ST_FUNC;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      result.frame_status  = status;
      result.function_code = func_in;
      result.register_low  = reg_in;
      result.value_word    = value_in;
      result.computed_crc  = crc_in;
      result.frame_length  = 9'(cnt_in);
   end

   // frame state; clears after the final byte
   always_ff @(posedge clock) begin
      if (reset || (step && in_word.end_of_frame)) begin
         crc_ff   <= CRC_START;
         held0_ff <= '0;
         held1_ff <= '0;
         cnt_ff   <= '0;
         addr_ff  <= '0;
         func_ff  <= '0;
         reg_ff   <= '0;
         value_ff <= '0;
      end else if (step) begin
         crc_ff   <= crc_in;
         held0_ff <= held0_in;
         held1_ff <= held1_in;
         cnt_ff   <= cnt_in;
         addr_ff  <= addr_in;
         func_ff  <= func_in;
         reg_ff   <= reg_in;
         value_ff <= value_in;
      end
   end

   a_clear_after_eof: assert property (@(posedge clock) disable iff (reset)
      step && in_word.end_of_frame |=> cnt_ff == '0 && crc_ff == CRC_START)
      else $error("frame state not cleared after final byte");

   a_cnt_saturates: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_SAT)
      else $error("byte counter beyond saturation");

   a_ok_length: assert property (@(posedge clock) disable iff (reset)
      status == ST_OK |-> cnt_in >= CNT_MIN && cnt_in <= CNT_MAX)
      else $error("accepted status with bad length");

endmodule

### design/modbus_rtu_frame_checker.sv
// Modbus RTU frame checker: CRC-16/MODBUS, length, address, function per frame.
// Throughput: one byte per cycle with no gaps between frames; a final byte waits
// while rsp_stall holds a full result register. Byte-wide CRC step and check logic
// lie between the input register and the result register that drives rsp_valid.
// Synchronous reset clears frame state and both valid bits; station address -> 1.
module modbus_rtu_frame_checker import mrfc_pkg::*; #(
   parameter int MAX_FRAME_BYTES = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_write_enable,
   input  logic [7:0]   csr_write_data
);

   logic         s1_valid_ff, s1_valid_in;
   req_word_type s1_word_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff;
   logic [7:0]   station_ff;
   logic         out_free;
   logic         step;
   logic         load_out;
   logic         req_accept;
   rsp_word_type core_result;

   // pipeline control: a final byte waits only for a free result register
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign step       = s1_valid_ff && (!s1_word_ff.end_of_frame || out_free);
   assign load_out   = step && s1_word_ff.end_of_frame;
   assign req_stall  = s1_valid_ff && !step;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_accept ? 1'b1 : (step ? 1'b0 : s1_valid_ff);
   assign out_valid_in = load_out ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_accept) begin
         s1_word_ff <= req_word;
      end
   end

   // station address register
   always_ff @(posedge clock) begin
      if (reset) begin
         station_ff <= 8'd1;
      end else if (csr_write_enable) begin
         station_ff <= csr_write_data;
      end
   end

   mrfc_frame_core #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .in_word        (s1_word_ff),
      .station_address(station_ff),
      .result         (core_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (load_out) begin
         out_word_ff <= core_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   a_stall_only_final: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s1_word_ff.end_of_frame && out_valid_ff)
      else $error("input stalled without a blocked final byte");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load_out |=> rsp_valid)
      else $error("loaded result not presented");

endmodule

### verif/modbus_rtu_frame_checker_tb.sv
`timescale 1ns / 100ps

module modbus_rtu_frame_checker_tb;
   import mrfc_pkg::*;

   localparam int FRAME_MAX  = 256;
   localparam int CYCLE_CAP  = 300000;
   localparam int HOLD_LONG  = 400;
   localparam int SETTLE     = 6;
   localparam int SHOW_LIMIT = 10;

   // directed stimulus, with the result typed in where it is obvious
   typedef struct {
      logic [7:0]   data;
      logic         eof;
      bit           typed;
      rsp_word_type want;
   } directed_row_type;

   localparam rsp_word_type NONE = '0;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_write_enable = 1'b0;
   logic [7:0]   csr_write_data = 8'h00;

   // frame checker model state
   logic [7:0]   station;
   logic [15:0]  acc_crc;
   logic [7:0]   held_old;
   logic [7:0]   held_new;
   logic [8:0]   seen_count;
   logic [7:0]   addr_seen;
   logic [7:0]   func_seen;
   logic [7:0]   reg_seen;
   logic [15:0]  value_seen;

   rsp_word_type     pending_status[$];
   logic [7:0]       frame_bytes[$];
   directed_row_type directed_rows[24];

   int           bytes_sent = 0;
   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           req_gap_pct = 0;
   int           rsp_stall_pct = 0;
   bit           pressure_req = 1'b0;
   bit           pressure_done = 1'b0;
   int           hold_left = 0;
   int           stall_left = 0;

   modbus_rtu_frame_checker u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // reflected CRC, data bit folded into the feedback tap
   function automatic logic [15:0] modbus_crc_step(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c;
      for (int k = 0; k < 8; k++) begin
         r = {1'b0, r[15:1]} ^ ((r[0] ^ b[k]) ? CRC_POLY : 16'h0000);
      end
      return r;
   endfunction

   task automatic clear_frame();
      acc_crc    = CRC_START;
      held_old   = 8'h00;
      held_new   = 8'h00;
      seen_count = '0;
      addr_seen  = 8'h00;
      func_seen  = 8'h00;
      reg_seen   = 8'h00;
      value_seen = 16'h0000;
   endtask

   // one accepted byte through the model; a status comes out on the last byte
   task automatic judge_byte(input logic [7:0] b, input logic eof,
                             output bit has_status, output rsp_word_type st);
      logic [8:0]  pos;
      logic [15:0] rx_crc;
      logic [2:0]  code;
      pos = seen_count;
      if (pos >= 2) begin
         acc_crc = modbus_crc_step(acc_crc, held_old);
      end
      held_old = held_new;
      held_new = b;
      case (pos)
         9'd0: addr_seen = b;
         9'd1: func_seen = b;
         9'd3: reg_seen = b;
         9'd4: value_seen[15:8] = b;
         9'd5: value_seen[7:0] = b;
         default: ;
      endcase
      if (seen_count < FRAME_MAX + 1) begin
         seen_count = seen_count + 9'd1;
      end
      has_status = eof;
      st = NONE;
      if (eof) begin
         rx_crc = {held_old, held_new};
         if (seen_count < MIN_FRAME_BYTES) begin
            code = ST_SHORT;
         end else if (seen_count > FRAME_MAX) begin
            code = ST_LONG;
         end else if (acc_crc != rx_crc) begin
            code = ST_CRC;
         end else if (addr_seen != station) begin
            code = ST_ADDR;
         end else if (func_seen != FN_READ_HOLDING && func_seen != FN_READ_INPUT &&
                      func_seen != FN_WRITE_SINGLE) begin
            code = ST_FUNC;
         end else begin
            code = ST_OK;
         end
         st = '{code, func_seen, reg_seen, value_seen, acc_crc, seen_count};
         clear_frame();
      end
   endtask

   // offer one word, hold it until accepted, then predict
   task automatic send_byte(input logic [7:0] b, input logic eof,
                            input bit typed, input rsp_word_type want);
      bit           has_status;
      rsp_word_type st;
      if (req_gap_pct != 0 && $urandom_range(1, 100) <= req_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= '{b, eof};
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      judge_byte(b, eof, has_status, st);
      if (has_status) begin
         pending_status.push_back(typed ? want : st);
      end
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) begin
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, NONE);
      end
   endtask

   // address, function, random body, then the CRC high byte first; one bit flipped when corrupt
   task automatic build_frame(input logic [7:0] addr, input logic [7:0] func,
                              input int len, input bit corrupt);
      logic [15:0] c;
      int          at;
      frame_bytes.delete();
      frame_bytes.push_back(addr);
      frame_bytes.push_back(func);
      for (int i = 2; i < len - 2; i++) begin
         frame_bytes.push_back(8'($urandom));
      end
      c = CRC_START;
      foreach (frame_bytes[i]) begin
         c = modbus_crc_step(c, frame_bytes[i]);
      end
      frame_bytes.push_back(c[15:8]);
      frame_bytes.push_back(c[7:0]);
      if (corrupt) begin
         at = $urandom_range(0, len - 1);
         frame_bytes[at] = frame_bytes[at] ^ (8'h01 << $urandom_range(0, 7));
      end
   endtask

   function automatic logic [7:0] pick_function();
      case ($urandom_range(0, 2))
         0: return FN_READ_HOLDING;
         1: return FN_READ_INPUT;
         default: return FN_WRITE_SINGLE;
      endcase
   endfunction

   // mostly good frames with random content, mixed with bad ones and noise
   task automatic random_frame();
      int          kind;
      int          len;
      logic [7:0]  addr;
      kind = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 40) : $urandom_range(4, 12);
      addr = ($urandom_range(0, 3) == 0) ? 8'($urandom) : station;
      if (kind < 60) begin
         build_frame(station, pick_function(), len, 1'b0);
      end else if (kind < 70) begin
         build_frame(addr, 8'($urandom), len, 1'b0);
      end else if (kind < 80) begin
         build_frame(addr, pick_function(), len, 1'b1);
      end else begin
         frame_bytes.delete();
         len = (kind < 88) ? $urandom_range(1, 3) : $urandom_range(1, 20);
         repeat (len) frame_bytes.push_back(8'($urandom));
      end
      send_frame();
   endtask

   task automatic run_random(input int target);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < target) begin
         random_frame();
      end
   endtask

   // stop offering and let every result and the pipeline drain
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_station(input logic [7:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      station = v;
   endtask

   // receiver: random stall bursts plus one long hold-off
   always @(posedge clock) begin
      if (pressure_req && !pressure_done) begin
         pressure_done <= 1'b1;
         hold_left     <= HOLD_LONG;
         rsp_stall     <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (rsp_stall_pct != 0 && $urandom_range(1, 100) <= rsp_stall_pct) begin
         stall_left <= $urandom_range(0, 18);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare each status word against the oldest prediction
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_status.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= SHOW_LIMIT) begin
               $display("unexpected status word %h", rsp_word);
            end
         end else begin
            want = pending_status.pop_front();
            if (rsp_word.frame_status !== want.frame_status ||
                rsp_word.function_code !== want.function_code ||
                rsp_word.register_low !== want.register_low ||
                rsp_word.value_word !== want.value_word ||
                rsp_word.computed_crc !== want.computed_crc ||
                rsp_word.frame_length !== want.frame_length) begin
               mismatch_count++;
               if (mismatch_count <= SHOW_LIMIT) begin
                  $display("status mismatch: exp st=%0d fn=%h reg=%h val=%h crc=%h len=%0d",
                           want.frame_status, want.function_code, want.register_low,
                           want.value_word, want.computed_crc, want.frame_length);
                  $display("                 got st=%0d fn=%h reg=%h val=%h crc=%h len=%0d",
                           rsp_word.frame_status, rsp_word.function_code,
                           rsp_word.register_low, rsp_word.value_word,
                           rsp_word.computed_crc, rsp_word.frame_length);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      directed_rows = '{
         // one byte: short, nothing latched but the address
         '{8'hFF, 1'b1, 1'b1, '{ST_SHORT, 8'h00, 8'h00, 16'h0000, 16'hFFFF, 9'd1}},
         // two bytes: short, function latched, crc untouched
         '{8'h00, 1'b0, 1'b0, NONE},
         '{8'h80, 1'b1, 1'b1, '{ST_SHORT, 8'h80, 8'h00, 16'h0000, 16'hFFFF, 9'd2}},
         // three bytes: crc covers the address only
         '{8'h01, 1'b0, 1'b0, NONE},
         '{8'h03, 1'b0, 1'b0, NONE},
         '{8'h00, 1'b1, 1'b0, NONE},
         // read holding registers, good crc sent high byte first
         '{8'h01, 1'b0, 1'b0, NONE},
         '{8'h03, 1'b0, 1'b0, NONE},
         '{8'h00, 1'b0, 1'b0, NONE},
         '{8'h00, 1'b0, 1'b0, NONE},
         '{8'h00, 1'b0, 1'b0, NONE},
         '{8'h0A, 1'b0, 1'b0, NONE},
         '{8'hCD, 1'b0, 1'b0, NONE},
         '{8'hC5, 1'b1, 1'b0, NONE},
         // shortest legal length, register byte sits in the crc pair
         '{8'h01, 1'b0, 1'b0, NONE},
         '{8'h04, 1'b0, 1'b0, NONE},
         '{8'h12, 1'b0, 1'b0, NONE},
         '{8'h34, 1'b1, 1'b0, NONE},
         // all-ones body, address zero
         '{8'h00, 1'b0, 1'b0, NONE},
         '{8'hFF, 1'b0, 1'b0, NONE},
         '{8'hFF, 1'b0, 1'b0, NONE},
         '{8'hFF, 1'b0, 1'b0, NONE},
         '{8'hFF, 1'b0, 1'b0, NONE},
         '{8'hFF, 1'b1, 1'b0, NONE}
      };
      station = 8'h01;
      clear_frame();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words at the reset address
      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].data, directed_rows[i].eof,
                   directed_rows[i].typed, directed_rows[i].want);
      end
      drain();

      // address zero, long receiver hold-off while frames keep coming
      set_station(8'h00);
      req_gap_pct   = 10;
      rsp_stall_pct = 10;
      pressure_req  = 1'b1;
      run_random(150);
      drain();

      // top address with a full-size legal frame
      set_station(8'hFF);
      req_gap_pct   = 30;
      rsp_stall_pct = 30;
      build_frame(station, FN_READ_INPUT, FRAME_MAX, 1'b0);
      send_frame();
      run_random(100);
      drain();

      // random address with an oversize frame, one past the counter saturation
      set_station(8'($urandom));
      req_gap_pct   = 5;
      rsp_stall_pct = 5;
      build_frame(station, FN_WRITE_SINGLE, FRAME_MAX + 2, 1'b0);
      send_frame();
      run_random(120);
      drain();

      // back to the reset address, full rate on both sides
      set_station(8'h01);
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      run_random(100);
      drain();

      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
